// ===== rtl/ucbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucbb_pkg
// Shared types, codes and widths of the uniform cubic B-spline basis unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ucbb_pkg;

  // field widths
  localparam int TIME_W = 24;
  localparam int SEG_W  = 16;
  localparam int DM_W   = TIME_W + SEG_W;     // d * m and (x << 16) numerators
  localparam int Q_W    = TIME_W + 16;        // tau and Dt, unsigned Q.32
  localparam int W_W    = 64;                 // weights, Q31.32

  // Q.32 product unit: a (48 bit) times b (40 bit), result >> 32 (56 bit)
  localparam int MA_W   = 48;
  localparam int MB_W   = 40;
  localparam int MP_W   = MA_W + MB_W - 32;

  // latencies of the pipelined parts
  localparam int KDIV_LAT = SEG_W;            // segment divider, one bit a stage
  localparam int TDIV_LAT = DM_W;             // tau and Dt dividers
  localparam int MUL_LAT  = 3;
  localparam int D6_LAT   = 6;
  localparam int PIPE_LAT = 2 + KDIV_LAT + 1 + TDIV_LAT + 2 * MUL_LAT + 2 + D6_LAT;

  // divide by three of an 18 bit value: (v * D3_RECIP) >> D3_SHIFT
  localparam logic [18:0] D3_RECIP = 19'd349526;
  localparam int          D3_SHIFT = 20;

  // register reset values
  localparam logic [TIME_W-1:0] START_RST = 24'h000000;
  localparam logic [TIME_W-1:0] END_RST   = 24'h010000;
  localparam logic [SEG_W-1:0]  NPTS_RST  = 16'd4;
  localparam logic [SEG_W-1:0]  NPTS_MIN  = 16'd4;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_NPTS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ORD_VALUE  = 2'd0,
    ORD_FIRST  = 2'd1,
    ORD_SECOND = 2'd2,
    ORD_BAD    = 2'd3
  } ord_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_SAT       = 2'd2
  } status_t;

  // item sideband carried alongside the arithmetic
  typedef struct packed {
    logic [SEG_W-1:0] seg;
    ord_t             ord;
  } side_t;

  // operands held over the second product level
  typedef struct packed {
    logic [Q_W-1:0]  tau;
    logic [Q_W-1:0]  dt;
    logic [MA_W-1:0] t2;
    logic [MA_W-1:0] d2;
    logic [MA_W-1:0] dtau;
    side_t           side;
  } m2_carry_t;

  // sideband of the output end
  typedef struct packed {
    logic [SEG_W-1:0] seg;
    status_t          status;
  } out_side_t;

endpackage

`default_nettype wire

// ===== rtl/ucbb_delay.sv =====
// ----------------------------------------------------------------------------
// ucbb_delay
// Enabled shift line that carries a payload alongside a pipelined unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbb_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] taps [N];

  // first tap
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
    end
  end

  // remaining taps
  for (genvar g = 1; g < N; g++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        taps[g] <= taps[g-1];
      end
    end
  end

  assign dout = taps[N-1];

endmodule

`default_nettype wire

// ===== rtl/ucbb_pdiv.sv =====
// ----------------------------------------------------------------------------
// ucbb_pdiv
// Pipelined restoring divider, one quotient bit per stage. The partial
// remainder starts at rem_in, which must be below den.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbb_pdiv #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] rem_in,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic      [DEN_W-1:0] rem
);

  // stage 0 is the input, stage g+1 the register after step g
  logic [NUM_W-1:0] nr [NUM_W+1];
  logic [DEN_W-1:0] rr [NUM_W+1];
  logic [DEN_W-1:0] dr [NUM_W+1];

  assign nr[0] = num;
  assign rr[0] = rem_in;
  assign dr[0] = den;

  for (genvar g = 0; g < NUM_W; g++) begin : g_step
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;

    // shift in the next dividend bit, subtract where it fits
    always_comb begin
      trial    = {rr[g], nr[g][NUM_W-1]};
      diff     = trial - {1'b0, dr[g]};
      ge       = (trial >= {1'b0, dr[g]});
      rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_next = {nr[g][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nr[g+1] <= num_next;
        rr[g+1] <= rem_next;
        dr[g+1] <= dr[g];
      end
    end
  end

  assign quo = nr[NUM_W];
  assign rem = rr[NUM_W];

endmodule

`default_nettype wire

// ===== rtl/ucbb_mulq.sv =====
// ----------------------------------------------------------------------------
// ucbb_mulq
// Three stage Q.32 product: exact (a * b) >> 32 from four partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbb_mulq
  import ucbb_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [MA_W-1:0] a,
  input  wire logic [MB_W-1:0] b,
  output logic      [MP_W-1:0] p
);

  localparam int AH = MA_W / 2;
  localparam int BH = MB_W / 2;
  localparam int PP_W = AH + BH;
  localparam int FULL_W = MA_W + MB_W;

  logic [PP_W-1:0]   pp_hh, pp_hl, pp_lh, pp_ll;
  logic [FULL_W-1:0] s_hi, s_lo;
  logic [FULL_W-1:0] full;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a[MA_W-1:AH] * b[MB_W-1:BH];
      pp_hl <= a[MA_W-1:AH] * b[BH-1:0];
      pp_lh <= a[AH-1:0]    * b[MB_W-1:BH];
      pp_ll <= a[AH-1:0]    * b[BH-1:0];
    end
  end

  // stage 2: a_hi * b and a_lo * b
  always_ff @(posedge clk) begin
    if (en) begin
      s_hi <= (FULL_W'(pp_hh) << BH) + FULL_W'(pp_hl);
      s_lo <= (FULL_W'(pp_lh) << BH) + FULL_W'(pp_ll);
    end
  end

  // stage 3: full product
  always_ff @(posedge clk) begin
    if (en) begin
      full <= (s_hi << AH) + s_lo;
    end
  end

  assign p = full[FULL_W-1:32];

endmodule

`default_nettype wire

// ===== rtl/ucbb_div6.sv =====
// ----------------------------------------------------------------------------
// ucbb_div6
// Pipelined signed divide by six, truncating toward zero, with a bypass.
// Halves the magnitude, then divides by three sixteen bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbb_div6
  import ucbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [W_W-1:0] x,
  input  wire logic                  div,
  output logic signed      [W_W-1:0] y
);

  localparam int DIG   = 16;
  localparam int NDIG  = W_W / DIG;

  logic [W_W-1:0] wq   [NDIG+1];
  logic [1:0]     rm   [NDIG+1];
  logic [W_W-1:0] raw  [NDIG+1];
  logic           dv   [NDIG+1];
  logic           ng   [NDIG+1];
  logic [W_W-1:0] mag;

  // stage A: magnitude halved
  assign mag = x[W_W-1] ? (~x + 1'b1) : x;

  always_ff @(posedge clk) begin
    if (en) begin
      wq[0]  <= {1'b0, mag[W_W-1:1]};
      rm[0]  <= 2'd0;
      raw[0] <= x;
      dv[0]  <= div;
      ng[0]  <= x[W_W-1];
    end
  end

  // digit stages: long division by three
  for (genvar g = 0; g < NDIG; g++) begin : g_dig
    logic [DIG+1:0]  v;
    logic [36:0]     prod;
    logic [DIG-1:0]  qd;
    logic [DIG+1:0]  back;

    always_comb begin
      v    = {rm[g], wq[g][W_W-1 -: DIG]};
      prod = 37'(v) * 37'(D3_RECIP);
      qd   = prod[D3_SHIFT +: DIG];
      back = v - 18'(qd) * 18'd3;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wq[g+1]  <= {wq[g][W_W-DIG-1:0], qd};
        rm[g+1]  <= back[1:0];
        raw[g+1] <= raw[g];
        dv[g+1]  <= dv[g];
        ng[g+1]  <= ng[g];
      end
    end
  end

  // final stage: restore sign or pass the undivided value
  always_ff @(posedge clk) begin
    if (en) begin
      if (!dv[NDIG]) begin
        y <= raw[NDIG];
      end else if (ng[NDIG]) begin
        y <= ~wq[NDIG] + 1'b1;
      end else begin
        y <= wq[NDIG];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uniform_cubic_bspline_basis_unit.sv =====
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_basis_unit
// Segment search and the four uniform cubic B-spline weights (or their first
// or second derivatives), scaled by the knot spacing cubed.
// ----------------------------------------------------------------------------
// Pipeline: a result is held while the output is stalled.
// Throughput: one item per cycle unless the output stalls; the depth is set by the
// bit-per-stage dividers for the segment (16 stages) and for tau and spacing (40 stages).
// Reset: synchronous; registers return to start 0, end 1.0, four points,
// and every pipeline valid bit clears.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_cubic_bspline_basis_unit
  import ucbb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [TIME_W-1:0]        cfg_data,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [TIME_W-1:0] sample_time,
  input  wire logic [1:0]               deriv_order,
  // output channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [W_W-1:0]         weight_newest,
  output logic signed [W_W-1:0]         weight_second,
  output logic signed [W_W-1:0]         weight_third,
  output logic signed [W_W-1:0]         weight_oldest,
  output logic [SEG_W-1:0]              segment_index,
  output logic [1:0]                    status
);

  logic signed [TIME_W-1:0] start_time, end_time;
  logic [SEG_W-1:0]         num_ctrl_points;
  logic                     en;
  logic [PIPE_LAT-1:0]      vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time      <= START_RST;
      end_time        <= END_RST;
      num_ctrl_points <= NPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START: start_time      <= cfg_data;
        CFG_END:   end_time        <= cfg_data;
        CFG_NPTS:  num_ctrl_points <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // range quantities; the user must keep them constant while items are in flight, as the block leaves this unenforced
  logic                range_ok;
  logic [TIME_W:0]     span_diff;
  logic [TIME_W-1:0]   span;
  logic [SEG_W-1:0]    npts_eff, m;

  always_comb begin
    range_ok  = (end_time > start_time);
    span_diff = {end_time[TIME_W-1], end_time} - {start_time[TIME_W-1], start_time};
    span      = range_ok ? span_diff[TIME_W-1:0] : '0;
    npts_eff  = (num_ctrl_points < NPTS_MIN) ? NPTS_MIN : num_ctrl_points;
    m         = npts_eff - 16'd3;
  end

  // global advance: the whole line holds while the result is stalled
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // stage 1: clamp and offset from start
  logic signed [TIME_W-1:0] tc;
  logic [TIME_W:0]          d_diff;
  logic [TIME_W-1:0]        d1;
  ord_t                     ord1;

  always_comb begin
    if (sample_time < start_time) begin
      tc = start_time;
    end else if (sample_time > end_time) begin
      tc = end_time;
    end else begin
      tc = sample_time;
    end
    d_diff = {tc[TIME_W-1], tc} - {start_time[TIME_W-1], start_time};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= range_ok ? d_diff[TIME_W-1:0] : '0;
      ord1 <= ord_t'(deriv_order);
    end
  end

  // stage 2: d * m
  logic [DM_W-1:0] dm2;
  ord_t            ord2;

  always_ff @(posedge clk) begin
    if (en) begin
      dm2  <= {{SEG_W{1'b0}}, d1} * {{TIME_W{1'b0}}, m};
      ord2 <= ord1;
    end
  end

  // segment divider: (d * m) / span, quotient below 2^16
  logic [SEG_W-1:0]  q_k;
  logic [TIME_W-1:0] r_k;
  ord_t              ord_k;

  ucbb_pdiv #(.NUM_W(SEG_W), .DEN_W(TIME_W)) u_kdiv (
    .clk    (clk),
    .en     (en),
    .num    (dm2[SEG_W-1:0]),
    .rem_in (dm2[DM_W-1:SEG_W]),
    .den    (span),
    .quo    (q_k),
    .rem    (r_k)
  );

  ucbb_delay #(.W($bits(ord_t)), .N(KDIV_LAT)) u_kdly (
    .clk  (clk),
    .en   (en),
    .din  (ord2),
    .dout (ord_k)
  );

  // segment clamp: the last knot maps to N-1 with the full spacing left
  logic              last_knot;
  logic [TIME_W-1:0] u_u;
  side_t             side_u;

  assign last_knot = (q_k >= m);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!range_ok) begin
        u_u        <= '0;
        side_u.seg <= 16'd3;
      end else if (last_knot) begin
        u_u        <= span;
        side_u.seg <= m + 16'd2;
      end else begin
        u_u        <= r_k;
        side_u.seg <= q_k + 16'd3;
      end
      side_u.ord <= ord_k;
    end
  end

  // tau and spacing dividers, both by m
  logic [Q_W-1:0] tau_v, dt_v;
  side_t          side_v;

  ucbb_pdiv #(.NUM_W(DM_W), .DEN_W(SEG_W)) u_tdiv (
    .clk    (clk),
    .en     (en),
    .num    ({u_u, 16'd0}),
    .rem_in ('0),
    .den    (m),
    .quo    (tau_v),
    .rem    ()
  );

  ucbb_pdiv #(.NUM_W(DM_W), .DEN_W(SEG_W)) u_ddiv (
    .clk    (clk),
    .en     (en),
    .num    ({span, 16'd0}),
    .rem_in ('0),
    .den    (m),
    .quo    (dt_v),
    .rem    ()
  );

  ucbb_delay #(.W($bits(side_t)), .N(TDIV_LAT)) u_vdly (
    .clk  (clk),
    .en   (en),
    .din  (side_u),
    .dout (side_v)
  );

  // first product level: tau^2, Dt^2, Dt*tau
  logic [MP_W-1:0] t2_m, d2_m, dtau_m;
  logic [Q_W-1:0]  tau_m1, dt_m1;
  side_t           side_m1;

  ucbb_mulq u_m_t2 (.clk(clk), .en(en), .a({8'd0, tau_v}), .b(tau_v), .p(t2_m));
  ucbb_mulq u_m_d2 (.clk(clk), .en(en), .a({8'd0, dt_v}),  .b(dt_v),  .p(d2_m));
  ucbb_mulq u_m_dt (.clk(clk), .en(en), .a({8'd0, dt_v}),  .b(tau_v), .p(dtau_m));

  ucbb_delay #(.W(2 * Q_W + $bits(side_t)), .N(MUL_LAT)) u_m1dly (
    .clk  (clk),
    .en   (en),
    .din  ({tau_v, dt_v, side_v}),
    .dout ({tau_m1, dt_m1, side_m1})
  );

  // second product level: tau^3, Dt^3, Dt*tau^2, Dt^2*tau
  logic [MP_W-1:0] t3_m, d3_m, dt2_m, d2t_m;
  m2_carry_t       c_in, c_m2;

  ucbb_mulq u_m_t3  (.clk(clk), .en(en), .a(t2_m[MA_W-1:0]), .b(tau_m1), .p(t3_m));
  ucbb_mulq u_m_d3  (.clk(clk), .en(en), .a(d2_m[MA_W-1:0]), .b(dt_m1),  .p(d3_m));
  ucbb_mulq u_m_dt2 (.clk(clk), .en(en), .a(t2_m[MA_W-1:0]), .b(dt_m1),  .p(dt2_m));
  ucbb_mulq u_m_d2t (.clk(clk), .en(en), .a(d2_m[MA_W-1:0]), .b(tau_m1), .p(d2t_m));

  always_comb begin
    c_in.tau  = tau_m1;
    c_in.dt   = dt_m1;
    c_in.t2   = t2_m[MA_W-1:0];
    c_in.d2   = d2_m[MA_W-1:0];
    c_in.dtau = dtau_m[MA_W-1:0];
    c_in.side = side_m1;
  end

  ucbb_delay #(.W($bits(m2_carry_t)), .N(MUL_LAT)) u_m2dly (
    .clk  (clk),
    .en   (en),
    .din  (c_in),
    .dout (c_m2)
  );

  // combine stage 1: scaled terms in two partial sums per weight
  logic signed [W_W-1:0] vt, vd, vt2, vd2, vdt, vt3, vd3, vdt2, vd2t;
  logic signed [W_W-1:0] p_n [4];
  logic signed [W_W-1:0] q_n [4];
  logic signed [W_W-1:0] p_c1 [4];
  logic signed [W_W-1:0] q_c1 [4];
  logic                  div_c1;
  out_side_t             os_n, os_c1;

  always_comb begin
    vt   = $signed({24'd0, c_m2.tau});
    vd   = $signed({24'd0, c_m2.dt});
    vt2  = $signed({16'd0, c_m2.t2});
    vd2  = $signed({16'd0, c_m2.d2});
    vdt  = $signed({16'd0, c_m2.dtau});
    vt3  = $signed({8'd0, t3_m});
    vd3  = $signed({8'd0, d3_m});
    vdt2 = $signed({8'd0, dt2_m});
    vd2t = $signed({8'd0, d2t_m});
    for (int i = 0; i < 4; i++) begin
      p_n[i] = '0;
      q_n[i] = '0;
    end
    os_n.seg    = c_m2.side.seg;
    os_n.status = ST_OK;
    unique case (c_m2.side.ord)
      ORD_VALUE: begin
        p_n[0] = vt3;
        p_n[1] = 64'sd3 * vdt2 - 64'sd3 * vt3;
        q_n[1] = 64'sd3 * vd2t + vd3;
        p_n[2] = 64'sd3 * vt3 - 64'sd6 * vdt2;
        q_n[2] = 64'sd4 * vd3;
        p_n[3] = 64'sd3 * vdt2 - vt3;
        q_n[3] = vd3 - 64'sd3 * vd2t;
      end
      ORD_FIRST: begin
        p_n[0] = 64'sd3 * vt2;
        p_n[1] = 64'sd6 * vdt - 64'sd9 * vt2;
        q_n[1] = 64'sd3 * vd2;
        p_n[2] = 64'sd9 * vt2 - 64'sd12 * vdt;
        p_n[3] = 64'sd6 * vdt - 64'sd3 * vt2;
        q_n[3] = -(64'sd3 * vd2);
      end
      ORD_SECOND: begin
        p_n[0] = vt;
        p_n[1] = vd - 64'sd3 * vt;
        p_n[2] = 64'sd3 * vt - 64'sd2 * vd;
        p_n[3] = vd - vt;
      end
      ORD_BAD: begin
        os_n.status = ST_BAD_ORDER;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p_c1[i] <= p_n[i];
        q_c1[i] <= q_n[i];
      end
      div_c1 <= (c_m2.side.ord != ORD_SECOND);
      os_c1  <= os_n;
    end
  end

  // combine stage 2: full numerators
  logic signed [W_W-1:0] num_c2 [4];
  logic                  div_c2;
  out_side_t             os_c2, os_out;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num_c2[i] <= p_c1[i] + q_c1[i];
      end
      div_c2 <= div_c1;
      os_c2  <= os_c1;
    end
  end

  // divide by six for value and first derivative
  ucbb_div6 u_d6_0 (.clk(clk), .en(en), .x(num_c2[0]), .div(div_c2), .y(weight_newest));
  ucbb_div6 u_d6_1 (.clk(clk), .en(en), .x(num_c2[1]), .div(div_c2), .y(weight_second));
  ucbb_div6 u_d6_2 (.clk(clk), .en(en), .x(num_c2[2]), .div(div_c2), .y(weight_third));
  ucbb_div6 u_d6_3 (.clk(clk), .en(en), .x(num_c2[3]), .div(div_c2), .y(weight_oldest));

  ucbb_delay #(.W($bits(out_side_t)), .N(D6_LAT)) u_odly (
    .clk  (clk),
    .en   (en),
    .din  (os_c2),
    .dout (os_out)
  );

  assign segment_index = os_out.seg;
  assign status        = os_out.status;

  // checks
  a_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != ST_SAT))
    else $error("saturation status on a result");

  a_seg_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (segment_index >= 16'd3))
    else $error("segment index below three");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_ORDER) |->
      (weight_newest == 0 && weight_second == 0 && weight_third == 0 &&
       weight_oldest == 0))
    else $error("invalid order gave nonzero weights");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire
